// ===== rtl/pcbp_pkg.sv =====
// Shared types, codes and helpers for the prefix code bit packer.
`default_nettype none
package pcbp_pkg;

    // Request operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam int unsigned STORE_WIDTH  = 32;
    localparam int unsigned MAX_CODE_LEN = 32;
    localparam int unsigned LEN_W        = 6;
    localparam int unsigned CODE_LEN_CAP =
        (MAX_CODE_LEN < STORE_WIDTH) ? MAX_CODE_LEN : STORE_WIDTH;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CODE_LEN_CAP);

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BCOUNT_W = 4;
    localparam logic [BCOUNT_W-1:0] BYTE_FULL = BCOUNT_W'(BYTE_W);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Work item passed from the front end to the packer
    typedef struct packed {
        logic                   flush;
        logic [STORE_WIDTH-1:0] code;
        logic [LEN_W-1:0]       len;
    } entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ENCODE,
        BK_FLUSH
    } bk_state_t;

    // Reverse a byte so that code bit 0 lands in bit 7
    function automatic logic [BYTE_W-1:0] byte_reverse(input logic [BYTE_W-1:0] value);
        logic [BYTE_W-1:0] result;
        for (int i = 0; i < BYTE_W; i++) begin
            result[i] = value[BYTE_W-1-i];
        end
        return result;
    endfunction

    // Mask with the top n bits of a byte set
    function automatic logic [BYTE_W-1:0] top_mask(input logic [BCOUNT_W-1:0] n);
        return ~({BYTE_W{1'b1}} >> n);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pcbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pcbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/pcbp_front.sv =====
// Front end: accept requests, maintain the code table, queue work for the packer.
`default_nettype none
module pcbp_front #(
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    operation,
    input  wire logic [7:0]                    symbol,
    input  wire logic [31:0]                   code_bits,
    input  wire logic [pcbp_pkg::LEN_W-1:0]    code_length,
    output logic                               q_push,
    output pcbp_pkg::entry_t                   q_data,
    input  wire logic                          q_full
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam logic [8:0] SYM_LIMIT = 9'(ALPHABET_SIZE);

    logic                          accept;
    logic                          in_range;
    logic                          wr_en;
    logic                          rd_en;
    logic [AW-1:0]                 addr;
    logic [pcbp_pkg::LEN_W-1:0]    len_sat;
    logic [pcbp_pkg::LEN_W-1:0]    ram_len;
    logic [pcbp_pkg::LEN_W-1:0]    len_eff;
    logic [31:0]                   ram_code;
    logic                          s1_take;
    logic                          s1_drain;

    logic [ALPHABET_SIZE-1:0]      valid_reg;
    logic [ALPHABET_SIZE-1:0]      valid_next;
    logic                          valid_rd_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_flush_reg;

    assign full     = s1_valid_reg && q_full;
    assign accept   = push && !full;
    assign in_range = {1'b0, symbol} < SYM_LIMIT;
    assign addr     = symbol[AW-1:0];
    assign wr_en    = accept && (operation == pcbp_pkg::OP_LOAD) && in_range;
    assign rd_en    = accept && (operation == pcbp_pkg::OP_ENCODE) && in_range;
    assign len_sat  = (code_length > pcbp_pkg::LEN_CAP) ? pcbp_pkg::LEN_CAP : code_length;

    // only encodes in range and flushes travel further
    assign s1_take  = rd_en || (accept && (operation == pcbp_pkg::OP_FLUSH));
    assign s1_drain = s1_valid_reg && !q_full;

    pcbp_ram #(
        .WIDTH (32),
        .DEPTH (ALPHABET_SIZE)
    ) u_code_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (addr),
        .wdata (code_bits),
        .re    (rd_en),
        .raddr (addr),
        .rdata (ram_code)
    );

    pcbp_ram #(
        .WIDTH (pcbp_pkg::LEN_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_len_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (addr),
        .wdata (len_sat),
        .re    (rd_en),
        .raddr (addr),
        .rdata (ram_len)
    );

    // a symbol never loaded reads as length zero
    assign len_eff = valid_rd_reg ? ram_len : '0;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[addr] = 1'b1;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_drain)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_flush_reg <= (operation == pcbp_pkg::OP_FLUSH);
        end
        if (rd_en)
        begin
            valid_rd_reg <= valid_reg[addr];
        end
    end

    // drop encodes that carry no code bits
    assign q_push      = s1_drain && (s1_flush_reg || (len_eff != '0));
    assign q_data.flush = s1_flush_reg;
    assign q_data.code  = ram_code;
    assign q_data.len   = len_eff;

endmodule
`default_nettype wire

// ===== rtl/pcbp_fifo.sv =====
// Short work queue between the front end and the packer.
`default_nettype none
module pcbp_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pcbp_pkg::entry_t wdata,
    output logic                  full,
    input  wire logic             pop,
    output pcbp_pkg::entry_t      rdata,
    output logic                  empty
);

    pcbp_pkg::entry_t                   slot_reg [pcbp_pkg::QUEUE_DEPTH];
    logic [pcbp_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [pcbp_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [pcbp_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [pcbp_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [pcbp_pkg::QCNT_W-1:0]        count_reg;
    logic [pcbp_pkg::QCNT_W-1:0]        count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full    = (count_reg == pcbp_pkg::QCNT_W'(pcbp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == pcbp_pkg::QPTR_W'(pcbp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pcbp_pkg::QPTR_W'(pcbp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pcbp_back.sv =====
// Back end: pack code bits into bytes and drive the result register.
`default_nettype none
module pcbp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pcbp_pkg::entry_t     q_data,
    input  wire logic                 q_empty,
    output logic                      q_pop,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [7:0]                out_byte,
    output logic                      last_byte
);

    pcbp_pkg::bk_state_t                state_reg;
    pcbp_pkg::bk_state_t                state_next;
    logic [pcbp_pkg::STORE_WIDTH-1:0]   code_reg;
    logic [pcbp_pkg::STORE_WIDTH-1:0]   code_next;
    logic [pcbp_pkg::LEN_W-1:0]         rem_reg;
    logic [pcbp_pkg::LEN_W-1:0]         rem_next;
    logic [7:0]                         pend_byte_reg;
    logic [7:0]                         pend_byte_next;
    logic [pcbp_pkg::BCOUNT_W-1:0]      pend_cnt_reg;
    logic [pcbp_pkg::BCOUNT_W-1:0]      pend_cnt_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [7:0]                         out_byte_reg;
    logic                               out_last_reg;

    logic                               out_free;
    logic                               pend_full;
    logic [pcbp_pkg::BCOUNT_W-1:0]      base_cnt;
    logic [7:0]                         base_byte;
    logic [pcbp_pkg::BCOUNT_W-1:0]      room;
    logic [pcbp_pkg::BCOUNT_W-1:0]      take;
    logic [7:0]                         add_bits;
    logic [pcbp_pkg::LEN_W-1:0]         rem_after;
    logic                               need_emit;
    logic                               step_ok;
    logic                               emit;
    logic                               emit_last;

    assign out_free  = !out_valid_reg || pop;
    assign pend_full = (pend_cnt_reg == pcbp_pkg::BYTE_FULL);

    // a full pending byte leaves when the next bit arrives or on a flush
    assign base_cnt  = pend_full ? '0 : pend_cnt_reg;
    assign base_byte = pend_full ? '0 : pend_byte_reg;
    assign room      = pcbp_pkg::BYTE_FULL - base_cnt;
    assign take      = (rem_reg < pcbp_pkg::LEN_W'(room))
                       ? rem_reg[pcbp_pkg::BCOUNT_W-1:0] : room;
    assign add_bits  = (pcbp_pkg::byte_reverse(code_reg[7:0]) & pcbp_pkg::top_mask(take))
                       >> base_cnt;
    assign rem_after = rem_reg - pcbp_pkg::LEN_W'(take);
    assign need_emit = pend_full && (rem_reg != '0);
    assign step_ok   = !need_emit || out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcbp_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_data.flush ? pcbp_pkg::BK_FLUSH : pcbp_pkg::BK_ENCODE;
                end
            end
            pcbp_pkg::BK_ENCODE:
            begin
                if (step_ok && (rem_after == '0))
                begin
                    state_next = pcbp_pkg::BK_IDLE;
                end
            end
            pcbp_pkg::BK_FLUSH:
            begin
                if ((pend_cnt_reg == '0) || out_free)
                begin
                    state_next = pcbp_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pcbp_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        q_pop          = 1'b0;
        emit           = 1'b0;
        emit_last      = 1'b0;
        code_next      = code_reg;
        rem_next       = rem_reg;
        pend_byte_next = pend_byte_reg;
        pend_cnt_next  = pend_cnt_reg;
        case (state_reg)
            pcbp_pkg::BK_IDLE:
            begin
                q_pop = !q_empty;
                if (!q_empty)
                begin
                    code_next = q_data.code;
                    rem_next  = q_data.len;
                end
            end
            pcbp_pkg::BK_ENCODE:
            begin
                if (step_ok)
                begin
                    emit           = need_emit;
                    emit_last      = (rem_reg <= pcbp_pkg::LEN_W'(pcbp_pkg::BYTE_W));
                    pend_byte_next = base_byte | add_bits;
                    pend_cnt_next  = base_cnt + take;
                    code_next      = code_reg >> take;
                    rem_next       = rem_after;
                end
            end
            pcbp_pkg::BK_FLUSH:
            begin
                if ((pend_cnt_reg != '0) && out_free)
                begin
                    emit           = 1'b1;
                    emit_last      = 1'b1;
                    pend_byte_next = '0;
                    pend_cnt_next  = '0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcbp_pkg::BK_IDLE;
            pend_byte_reg <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_byte_reg <= pend_byte_next;
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        rem_reg  <= rem_next;
        if (emit)
        begin
            out_byte_reg <= pend_byte_reg;
            out_last_reg <= emit_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/prefix_code_bit_packer.sv =====
// Top level of the prefix code bit packer.
//
// Requests enter through a queue-style port: present operation, symbol,
// code_bits and code_length and raise push; a request is taken at an edge
// where push is high and full is low. A load writes a code word and its length
// (saturated at 32) into the table, an encode appends the symbol's code bits,
// first bit first, to the pending byte, and a flush sends a partly or fully
// filled pending byte and clears it. While empty is low, out_byte and last_byte
// show the oldest packed byte and pop takes it; last_byte marks the final byte
// of one request.
// Timing: the front end takes one request per cycle while the work queue has
// room; the table lookup and the queue are each registered. The packer picks
// up a job in its idle state, then moves up to 8 code bits per step into the
// pending byte, stalling while a full byte waits for the output register.
// At most one byte leaves per cycle. If pop stays low, hold the output byte,
// stall the packer, fill the queue and raise full.
// Reset: rst_n clears the pending byte, table valid bits, queue and output valid;
// unloaded symbols read as length zero, table code words stay undefined.
`default_nettype none
module prefix_code_bit_packer #(
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [1:0]                  operation,
    input  wire logic [7:0]                  symbol,
    input  wire logic [31:0]                 code_bits,
    input  wire logic [5:0]                  code_length,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [7:0]                       out_byte,
    output logic                             last_byte
);

    // front end to work queue
    logic               fq_push;
    pcbp_pkg::entry_t   fq_data;
    logic               fq_full;

    // work queue to packer
    logic               qb_pop;
    pcbp_pkg::entry_t   qb_data;
    logic               qb_empty;

    pcbp_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .q_push      (fq_push),
        .q_data      (fq_data),
        .q_full      (fq_full)
    );

    pcbp_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_data),
        .full  (fq_full),
        .pop   (qb_pop),
        .rdata (qb_data),
        .empty (qb_empty)
    );

    pcbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (qb_data),
        .q_empty   (qb_empty),
        .q_pop     (qb_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule
`default_nettype wire
